// ----- hw/rtl/blpg_pkg.sv -----
// ----------------------------------------------------------------------------
// blpg_pkg: shared types and constants for the Bresenham line pixel generator
// Request and pixel payload structs, configuration register codes and widths.
// ----------------------------------------------------------------------------
package blpg_pkg;

    // Coordinate width of endpoints and pixels (signed)
    localparam int COORD_BITS    = 12;
    // Width of the screen size registers (unsigned)
    localparam int CFG_BITS      = 12;
    // Framebuffer index width
    localparam int INDEX_BITS    = 2 * COORD_BITS - 2;
    // Decision term width: covers -2*max_abs .. 2*max_abs
    localparam int DECISION_BITS = COORD_BITS + 3;

    localparam logic [CFG_BITS-1:0] SCREEN_RESET = CFG_BITS'(1024);

    typedef enum logic
    {
        MODE_LOAD = 1'b0,
        MODE_STEP = 1'b1
    } mode_t;

    typedef enum logic
    {
        CFG_SCREEN_WIDTH  = 1'b0,
        CFG_SCREEN_HEIGHT = 1'b1
    } cfg_index_t;

    typedef struct packed
    {
        mode_t                         mode;
        logic signed [COORD_BITS-1:0]  x_start;
        logic signed [COORD_BITS-1:0]  y_start;
        logic signed [COORD_BITS-1:0]  x_end;
        logic signed [COORD_BITS-1:0]  y_end;
    } line_req_t;

    typedef struct packed
    {
        logic signed [COORD_BITS-1:0]  pixel_x;
        logic signed [COORD_BITS-1:0]  pixel_y;
        logic                          visible;
        logic [INDEX_BITS-1:0]         pixel_index;
        logic                          last;
    } pixel_t;

endpackage

// ----- hw/rtl/bresenham_line_pixel_generator_unit.sv -----
// ----------------------------------------------------------------------------
// bresenham_line_pixel_generator_unit: Bresenham line pixel generator
// Sets up a line from two endpoints, then emits one clipped pixel per step.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req_data): a load request (mode LOAD)
//   sets up a new line from two endpoints and replaces any line in progress;
//   it produces no pixel. A step request (mode STEP) emits the current pixel
//   and advances one unit along the major axis. A step request with no
//   active line is taken and dropped.
//   pix channel (pix_valid/pix_ready/pix_data): one pixel per step request,
//   with clip flag, framebuffer index and a last flag on the line's end.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): screen width and
//   height; always ready, write only while no request is in flight.
// Latency and throughput: a pixel shows on pix_valid in the cycle after its
// step request is taken; one request per cycle is sustained while pix_ready
// holds. The pixel comes from the line registers through one add/compare and
// one 12x12 multiply combinationally into the output register.
// Stall: while a pixel waits in the output register, a step request that
// would emit is held off; loads and idle steps are still taken.
// Reset: no line active, output empty, screen size 1024 x 1024.
// ----------------------------------------------------------------------------
module bresenham_line_pixel_generator_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  blpg_pkg::line_req_t              req_data,
    output logic                             pix_valid,
    input  logic                             pix_ready,
    output blpg_pkg::pixel_t                 pix_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  blpg_pkg::cfg_index_t             cfg_index,
    input  logic [blpg_pkg::CFG_BITS-1:0]    cfg_data
);

    localparam int CB  = blpg_pkg::COORD_BITS;
    localparam int CW  = CB + 1;                      // working coordinate width
    localparam int DB  = blpg_pkg::DECISION_BITS;
    localparam int FB  = blpg_pkg::CFG_BITS;
    localparam int IB  = blpg_pkg::INDEX_BITS;
    localparam int CMP = ((CW > FB) ? CW : FB) + 1;   // signed clip compare width
    localparam int SB  = 2 * FB + 1;                  // index sum width

    // Configuration registers
    logic [FB-1:0] width_reg, width_next;
    logic [FB-1:0] height_reg, height_next;

    // Line state
    logic                 line_active_reg, line_active_next;
    logic signed [CW-1:0] cur_x_reg, cur_x_next;
    logic signed [CW-1:0] cur_y_reg, cur_y_next;
    logic signed [CB-1:0] major_end_reg, major_end_next;
    logic                 x_major_reg, x_major_next;
    logic                 step_up_reg, step_up_next;
    logic [CB-1:0]        abs_dx_reg, abs_dx_next;
    logic [CB-1:0]        abs_dy_reg, abs_dy_next;
    logic signed [DB-1:0] dec_reg, dec_next;

    // Output register
    logic                 pix_valid_reg, pix_valid_next;
    blpg_pkg::pixel_t     pix_data_reg, pix_data_next;

    // Handshake
    logic req_fire;
    logic emits;

    // Setup datapath
    logic signed [CW-1:0] x1, y1, x2, y2, dx, dy;
    logic [CB-1:0]        set_adx, set_ady;
    logic                 set_x_major, set_up;
    logic signed [DB-1:0] set_adx_ext, set_ady_ext, set_dec;
    logic signed [CW-1:0] set_x, set_y;
    logic signed [CB-1:0] set_end;

    // Step datapath
    logic                 is_last;
    logic signed [CW-1:0] minor_step;
    logic signed [DB-1:0] adx_ext, ady_ext, two_adx, two_ady, two_diff;
    logic signed [CMP-1:0] xc, yc, wc, hc, hy;
    logic                 vis;
    logic [FB-1:0]        hy_low, x_low;
    logic [SB-1:0]        idx_sum;

    // ------------------------------------------------------------------
    // Handshakes. A step on an active line is the only request that
    // needs room in the output register.
    // ------------------------------------------------------------------
    assign emits     = (req_data.mode == blpg_pkg::MODE_STEP) && line_active_reg;
    assign req_ready = pix_ready || !pix_valid_reg || !emits;
    assign req_fire  = req_valid && req_ready;
    assign cfg_ready = 1'b1;

    assign pix_valid = pix_valid_reg;
    assign pix_data  = pix_data_reg;

    // ------------------------------------------------------------------
    // Line setup: deltas, branch, start end, decision term, minor direction
    // ------------------------------------------------------------------
    always_comb
    begin
        x1 = CW'(req_data.x_start);
        y1 = CW'(req_data.y_start);
        x2 = CW'(req_data.x_end);
        y2 = CW'(req_data.y_end);
        dx = x2 - x1;
        dy = y2 - y1;

        set_adx = dx[CW-1] ? CB'(-dx) : CB'(dx);
        set_ady = dy[CW-1] ? CB'(-dy) : CB'(dy);

        // Minor axis goes up when both deltas are strictly the same sign
        set_up = (dx[CW-1] && dy[CW-1])
              || (!dx[CW-1] && (dx != '0) && !dy[CW-1] && (dy != '0));

        set_x_major = (set_ady <= set_adx);
        set_adx_ext = $signed(DB'(set_adx));
        set_ady_ext = $signed(DB'(set_ady));

        if (set_x_major)
        begin
            set_dec = (set_ady_ext <<< 1) - set_adx_ext;
            if (!dx[CW-1])
            begin
                set_x   = x1;
                set_y   = y1;
                set_end = req_data.x_end;
            end
            else
            begin
                set_x   = x2;
                set_y   = y2;
                set_end = req_data.x_start;
            end
        end
        else
        begin
            set_dec = (set_adx_ext <<< 1) - set_ady_ext;
            if (!dy[CW-1])
            begin
                set_x   = x1;
                set_y   = y1;
                set_end = req_data.y_end;
            end
            else
            begin
                set_x   = x2;
                set_y   = y2;
                set_end = req_data.y_start;
            end
        end
    end

    // ------------------------------------------------------------------
    // Current pixel: clip test, framebuffer index, end of line
    // ------------------------------------------------------------------
    always_comb
    begin
        xc = CMP'(cur_x_reg);
        yc = CMP'(cur_y_reg);
        wc = $signed(CMP'(width_reg));
        hc = $signed(CMP'(height_reg));

        vis = (xc > 0) && (xc < wc) && (yc > 0) && (yc < hc);

        // Inside the clip window both terms fit the register width
        hy      = hc - yc;
        hy_low  = hy[FB-1:0];
        x_low   = xc[FB-1:0];
        idx_sum = SB'(hy_low) * SB'(width_reg) + SB'(x_low);

        is_last = x_major_reg ? (cur_x_reg >= CW'(major_end_reg))
                              : (cur_y_reg >= CW'(major_end_reg));

        minor_step = step_up_reg ? CW'(1) : -CW'(1);
        adx_ext    = $signed(DB'(abs_dx_reg));
        ady_ext    = $signed(DB'(abs_dy_reg));
        two_adx    = adx_ext <<< 1;
        two_ady    = ady_ext <<< 1;
        two_diff   = x_major_reg ? ((ady_ext - adx_ext) <<< 1)
                                 : ((adx_ext - ady_ext) <<< 1);
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        width_next       = width_reg;
        height_next      = height_reg;
        line_active_next = line_active_reg;
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        major_end_next   = major_end_reg;
        x_major_next     = x_major_reg;
        step_up_next     = step_up_reg;
        abs_dx_next      = abs_dx_reg;
        abs_dy_next      = abs_dy_reg;
        dec_next         = dec_reg;
        pix_valid_next   = pix_valid_reg;
        pix_data_next    = pix_data_reg;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                blpg_pkg::CFG_SCREEN_WIDTH:  width_next  = cfg_data;
                blpg_pkg::CFG_SCREEN_HEIGHT: height_next = cfg_data;
                default:                     width_next  = width_reg;
            endcase
        end

        // Drain the output register when taken
        if (pix_valid_reg && pix_ready)
        begin
            pix_valid_next = 1'b0;
        end

        if (req_fire)
        begin
            if (req_data.mode == blpg_pkg::MODE_LOAD)
            begin
                line_active_next = 1'b1;
                cur_x_next       = set_x;
                cur_y_next       = set_y;
                major_end_next   = set_end;
                x_major_next     = set_x_major;
                step_up_next     = set_up;
                abs_dx_next      = set_adx;
                abs_dy_next      = set_ady;
                dec_next         = set_dec;
            end
            else if (line_active_reg)
            begin
                pix_valid_next            = 1'b1;
                pix_data_next.pixel_x     = CB'(cur_x_reg);
                pix_data_next.pixel_y     = CB'(cur_y_reg);
                pix_data_next.visible     = vis;
                pix_data_next.pixel_index = vis ? IB'(idx_sum) : '0;
                pix_data_next.last        = is_last;

                if (is_last)
                begin
                    line_active_next = 1'b0;
                end
                else if (x_major_reg)
                begin
                    cur_x_next = cur_x_reg + CW'(1);
                    if (dec_reg < 0)
                    begin
                        dec_next = dec_reg + two_ady;
                    end
                    else
                    begin
                        cur_y_next = cur_y_reg + minor_step;
                        dec_next   = dec_reg + two_diff;
                    end
                end
                else
                begin
                    cur_y_next = cur_y_reg + CW'(1);
                    if (dec_reg <= 0)
                    begin
                        dec_next = dec_reg + two_adx;
                    end
                    else
                    begin
                        cur_x_next = cur_x_reg + minor_step;
                        dec_next   = dec_reg + two_diff;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg       <= blpg_pkg::SCREEN_RESET;
            height_reg      <= blpg_pkg::SCREEN_RESET;
            line_active_reg <= 1'b0;
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            major_end_reg   <= '0;
            x_major_reg     <= 1'b0;
            step_up_reg     <= 1'b0;
            abs_dx_reg      <= '0;
            abs_dy_reg      <= '0;
            dec_reg         <= '0;
            pix_valid_reg   <= 1'b0;
        end
        else
        begin
            width_reg       <= width_next;
            height_reg      <= height_next;
            line_active_reg <= line_active_next;
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            major_end_reg   <= major_end_next;
            x_major_reg     <= x_major_next;
            step_up_reg     <= step_up_next;
            abs_dx_reg      <= abs_dx_next;
            abs_dy_reg      <= abs_dy_next;
            dec_reg         <= dec_next;
            pix_valid_reg   <= pix_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_data_reg <= pix_data_next;
    end

endmodule

// ----- hw/rtl/blpg_checker.sv -----
// ----------------------------------------------------------------------------
// blpg_checker: port-level checks for the line pixel generator
// Watches the request, pixel and configuration channels over time.
// ----------------------------------------------------------------------------
module blpg_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             req_valid,
    input logic                             req_ready,
    input blpg_pkg::line_req_t              req_data,
    input logic                             pix_valid,
    input logic                             pix_ready,
    input blpg_pkg::pixel_t                 pix_data,
    input logic                             cfg_valid,
    input logic                             cfg_ready
);

    // Hold a stalled pixel
    a_pix_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_ready |=> pix_valid && $stable(pix_data))
        else $error("stalled pixel changed or dropped");

    // A new pixel only follows an accepted step request
    a_pix_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && !$past(pix_valid && !pix_ready))
        |-> $past(req_valid && req_ready && (req_data.mode == blpg_pkg::MODE_STEP)))
        else $error("pixel without a step request");

    // Clipped pixels carry a zero index
    a_clip_index: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_data.visible |-> (pix_data.pixel_index == '0))
        else $error("invisible pixel with nonzero index");

    // Visible pixels lie strictly inside the positive quadrant
    a_vis_coords: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_data.visible
        |-> (pix_data.pixel_x > 0) && (pix_data.pixel_y > 0))
        else $error("visible pixel outside the screen");

    // Register writes are taken at once
    a_cfg_taken: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("register write held off");

endmodule

bind bresenham_line_pixel_generator_unit blpg_checker u_blpg_checker (.*);
